>>> rtl/isp_pkg.sv
// ----------------------------------------------------------------------------
// isp_pkg: shared types and constants for the sensor poll block
// Sequencer step codes, slot result word, register map and the
// thermometer-bar mapping for the received temperature byte.
// ----------------------------------------------------------------------------
package isp_pkg;

	// Register map
	localparam int unsigned ADDR_W = 3;
	localparam logic [0:0] REG_DEV_ADDR = 1'b0;
	localparam logic [0:0] REG_REG_PTR  = 1'b1;

	// Reset values of the configuration registers
	localparam logic [6:0] DEV_ADDR_RST = 7'd77;
	localparam logic [7:0] REG_PTR_RST  = 8'd0;

	// Thermometer band edges and relay trip point
	localparam logic [7:0] BAR_LO    = 8'd30;
	localparam logic [7:0] BAR_B1    = 8'd35;
	localparam logic [7:0] BAR_B2    = 8'd40;
	localparam logic [7:0] BAR_B3    = 8'd45;
	localparam logic [7:0] BAR_B4    = 8'd50;
	localparam logic [7:0] BAR_B5    = 8'd55;
	localparam logic [7:0] BAR_HI    = 8'd60;
	localparam logic [7:0] RELAY_TEMP = 8'd50;

	// Bit counts within a START or STOP condition and per byte
	localparam logic [3:0] COND_PH0   = 4'd0;
	localparam logic [3:0] COND_PH1   = 4'd1;
	localparam logic [3:0] COND_PH2   = 4'd2;
	localparam logic [3:0] BYTE_BITS  = 4'd8;

	// Transaction sequencer steps
	typedef enum logic [3:0] {
		ST_IDLE    = 4'd0,
		ST_START   = 4'd1,
		ST_ADDRW   = 4'd2,
		ST_ACK1    = 4'd3,
		ST_REG     = 4'd4,
		ST_ACK2    = 4'd5,
		ST_RESTART = 4'd6,
		ST_ADDRR   = 4'd7,
		ST_ACK3    = 4'd8,
		ST_READ    = 4'd9,
		ST_NACK    = 4'd10,
		ST_STOP    = 4'd11
	} step_t;

	// One slot's result word
	typedef struct packed {
		logic       scl_level;
		logic       sda_level;
		logic       sda_drive;
		logic       busy_res;
		logic       reading_valid;
		logic [7:0] temperature;
		logic [5:0] led_bar;
		logic       relay_on;
	} slot_res_t;

	// Map a temperature to the six-LED thermometer code
	function automatic logic [5:0] bar_of(input logic [7:0] t);
		logic [5:0] bar;
		if (t < BAR_LO || t > BAR_HI) begin
			bar = 6'h00;
		end else if (t < BAR_B1) begin
			bar = 6'h01;
		end else if (t < BAR_B2) begin
			bar = 6'h03;
		end else if (t < BAR_B3) begin
			bar = 6'h07;
		end else if (t < BAR_B4) begin
			bar = 6'h0F;
		end else if (t < BAR_B5) begin
			bar = 6'h1F;
		end else begin
			bar = 6'h3F;
		end
		return bar;
	endfunction

endpackage

>>> rtl/isp_if.sv
// ----------------------------------------------------------------------------
// isp_if: valid/ready channels of the sensor poll block
// Input channel carries one bus slot (start request, sampled SDA); output
// channel carries the bus levels and the latest reading for that slot.
// ----------------------------------------------------------------------------
interface isp_in_if;
	logic valid;
	logic ready;
	logic start_request;
	logic sda_in;

	modport source (output valid, output start_request, output sda_in, input ready);
	modport sink   (input valid, input start_request, input sda_in, output ready);
endinterface

interface isp_out_if;
	logic       valid;
	logic       ready;
	logic       scl_level;
	logic       sda_level;
	logic       sda_drive;
	logic       busy_res;
	logic       reading_valid;
	logic [7:0] temperature;
	logic [5:0] led_bar;
	logic       relay_on;

	modport source (
		output valid, output scl_level, output sda_level, output sda_drive,
		output busy_res, output reading_valid, output temperature,
		output led_bar, output relay_on, input ready
	);
	modport sink (
		input valid, input scl_level, input sda_level, input sda_drive,
		input busy_res, input reading_valid, input temperature,
		input led_bar, input relay_on, output ready
	);
endinterface

>>> rtl/isp_seq.sv
// ----------------------------------------------------------------------------
// isp_seq: I2C register-read sequencer
// Walks START, address+W, pointer, repeated START, address+R, eight read
// bits, NACK and STOP, one slot per step enable; keeps the last reading.
// ----------------------------------------------------------------------------
module isp_seq (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step_en,
	input  logic                 start_request,
	input  logic                 sda_in,
	input  logic [6:0]           device_address,
	input  logic [7:0]           register_pointer,
	output isp_pkg::slot_res_t   res
);

	isp_pkg::step_t step_q, step_d, step_succ;
	logic [3:0]     bit_cnt_q, bit_cnt_d, bit_inc;
	logic           phase_q, phase_d;
	logic [7:0]     shift_q, shift_d;
	logic [7:0]     temp_q, temp_d;
	logic [5:0]     bar_q, bar_d;
	logic           relay_q, relay_d;
	logic           scl, lvl, drv, rd_valid;

	assign step_succ = isp_pkg::step_t'(step_q + 4'd1);
	assign bit_inc   = bit_cnt_q + 4'd1;

	// Next state of the sequencer and the reading
	always_comb begin
		step_d    = step_q;
		bit_cnt_d = bit_cnt_q;
		phase_d   = phase_q;
		shift_d   = shift_q;
		temp_d    = temp_q;
		bar_d     = bar_q;
		relay_d   = relay_q;
		unique case (step_q)
			isp_pkg::ST_START, isp_pkg::ST_RESTART: begin
				if (bit_cnt_q == isp_pkg::COND_PH0) begin
					bit_cnt_d = isp_pkg::COND_PH1;
				end else if (bit_cnt_q == isp_pkg::COND_PH1) begin
					bit_cnt_d = isp_pkg::COND_PH2;
				end else begin
					bit_cnt_d = '0;
					phase_d   = 1'b0;
					if (step_q == isp_pkg::ST_START) begin
						step_d  = isp_pkg::ST_ADDRW;
						shift_d = {device_address, 1'b0};
					end else begin
						step_d  = isp_pkg::ST_ADDRR;
						shift_d = {device_address, 1'b1};
					end
				end
			end
			isp_pkg::ST_ADDRW, isp_pkg::ST_REG, isp_pkg::ST_ADDRR: begin
				if (!phase_q) begin
					phase_d = 1'b1;
				end else begin
					phase_d = 1'b0;
					shift_d = {shift_q[6:0], 1'b0};
					if (bit_inc >= isp_pkg::BYTE_BITS) begin
						bit_cnt_d = '0;
						step_d    = step_succ;
					end else begin
						bit_cnt_d = bit_inc;
					end
				end
			end
			isp_pkg::ST_ACK1, isp_pkg::ST_ACK2, isp_pkg::ST_ACK3: begin
				if (!phase_q) begin
					phase_d = 1'b1;
				end else begin
					phase_d   = 1'b0;
					bit_cnt_d = '0;
					step_d    = step_succ;
					if (step_q == isp_pkg::ST_ACK1) begin
						shift_d = register_pointer;
					end else if (step_q == isp_pkg::ST_ACK3) begin
						shift_d = '0;
					end
				end
			end
			isp_pkg::ST_READ: begin
				if (!phase_q) begin
					phase_d = 1'b1;
					shift_d = {shift_q[6:0], sda_in};
				end else begin
					phase_d = 1'b0;
					if (bit_inc >= isp_pkg::BYTE_BITS) begin
						bit_cnt_d = '0;
						step_d    = isp_pkg::ST_NACK;
					end else begin
						bit_cnt_d = bit_inc;
					end
				end
			end
			isp_pkg::ST_NACK: begin
				if (!phase_q) begin
					phase_d = 1'b1;
				end else begin
					phase_d   = 1'b0;
					bit_cnt_d = '0;
					step_d    = isp_pkg::ST_STOP;
				end
			end
			isp_pkg::ST_STOP: begin
				if (bit_cnt_q == isp_pkg::COND_PH0) begin
					bit_cnt_d = isp_pkg::COND_PH1;
				end else if (bit_cnt_q == isp_pkg::COND_PH1) begin
					bit_cnt_d = isp_pkg::COND_PH2;
				end else begin
					temp_d    = shift_q;
					bar_d     = isp_pkg::bar_of(shift_q);
					relay_d   = (shift_q == isp_pkg::RELAY_TEMP);
					bit_cnt_d = '0;
					phase_d   = 1'b0;
					step_d    = isp_pkg::ST_IDLE;
				end
			end
			default: begin
				// idle, and any unused step code
				step_d    = isp_pkg::ST_IDLE;
				bit_cnt_d = '0;
				phase_d   = 1'b0;
				if (start_request) begin
					step_d    = isp_pkg::ST_START;
					bit_cnt_d = isp_pkg::COND_PH1;
				end
			end
		endcase
	end

	// Bus levels driven for this slot
	always_comb begin
		scl      = 1'b1;
		lvl      = 1'b1;
		drv      = 1'b0;
		rd_valid = 1'b0;
		unique case (step_q)
			isp_pkg::ST_START, isp_pkg::ST_RESTART: begin
				drv = 1'b1;
				if (bit_cnt_q == isp_pkg::COND_PH0) begin
					scl = 1'b1;
					lvl = 1'b1;
				end else if (bit_cnt_q == isp_pkg::COND_PH1) begin
					scl = 1'b1;
					lvl = 1'b0;
				end else begin
					scl = 1'b0;
					lvl = 1'b0;
				end
			end
			isp_pkg::ST_ADDRW, isp_pkg::ST_REG, isp_pkg::ST_ADDRR: begin
				drv = 1'b1;
				lvl = shift_q[7];
				scl = !phase_q;
			end
			isp_pkg::ST_ACK1, isp_pkg::ST_ACK2, isp_pkg::ST_ACK3: begin
				lvl = 1'b0;
				scl = !phase_q;
				drv = phase_q;
			end
			isp_pkg::ST_READ: begin
				drv = 1'b0;
				lvl = 1'b0;
				scl = !phase_q;
			end
			isp_pkg::ST_NACK: begin
				drv = 1'b1;
				lvl = 1'b1;
				scl = !phase_q;
			end
			isp_pkg::ST_STOP: begin
				drv = 1'b1;
				if (bit_cnt_q == isp_pkg::COND_PH0) begin
					scl = 1'b0;
					lvl = 1'b0;
				end else if (bit_cnt_q == isp_pkg::COND_PH1) begin
					scl = 1'b1;
					lvl = 1'b0;
				end else begin
					scl      = 1'b1;
					lvl      = 1'b1;
					rd_valid = 1'b1;
				end
			end
			default: begin
				drv = start_request;
			end
		endcase
	end

	// Result word for this slot
	always_comb begin
		res.scl_level     = scl;
		res.sda_level     = lvl;
		res.sda_drive     = drv;
		res.busy_res      = (step_d != isp_pkg::ST_IDLE);
		res.reading_valid = rd_valid;
		res.temperature   = temp_d;
		res.led_bar       = bar_d;
		res.relay_on      = relay_d;
	end

	// Advance one slot per accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q    <= isp_pkg::ST_IDLE;
			bit_cnt_q <= '0;
			phase_q   <= 1'b0;
			shift_q   <= '0;
			temp_q    <= '0;
			bar_q     <= '0;
			relay_q   <= 1'b0;
		end else if (step_en) begin
			step_q    <= step_d;
			bit_cnt_q <= bit_cnt_d;
			phase_q   <= phase_d;
			shift_q   <= shift_d;
			temp_q    <= temp_d;
			bar_q     <= bar_d;
			relay_q   <= relay_d;
		end
	end

	a_stop_idles: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && rd_valid |-> !res.busy_res)
		else $error("reading completed while sequencer stays busy");

	a_bar_tracks_temp: assert property (@(posedge clk) disable iff (!arst_n)
		bar_q == isp_pkg::bar_of(temp_q) && relay_q == (temp_q == isp_pkg::RELAY_TEMP))
		else $error("bar or relay out of step with temperature");

	a_release_only_on_ack: assert property (@(posedge clk) disable iff (!arst_n)
		step_q != isp_pkg::ST_IDLE && !drv |->
		(step_q == isp_pkg::ST_READ || step_q == isp_pkg::ST_ACK1 ||
		 step_q == isp_pkg::ST_ACK2 || step_q == isp_pkg::ST_ACK3))
		else $error("SDA released outside acknowledge or read bit");

endmodule

>>> rtl/i2c_sensor_poll_bar_graph_top.sv
// ----------------------------------------------------------------------------
// i2c_sensor_poll_bar_graph_top: I2C sensor poll with LED bar and relay
// Bit-banged I2C register read, one bus slot per input word, with an APB
// register port for the slave address and the register pointer.
// ----------------------------------------------------------------------------
// Result word: registered, offered in the cycle after its slot is taken.
// Throughput: one slot word per cycle while out_ch is not stalled; the output
//   register takes a new word in the cycle its old one is drained.
// A full read transaction spans 81 slots from the start request to STOP.
// Reset (arst_n low): sequencer idle, reading, bar and relay zero, address 77,
//   pointer 0, output register empty.
module i2c_sensor_poll_bar_graph_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [isp_pkg::ADDR_W-1:0]  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	isp_in_if.sink                      in_ch,
	isp_out_if.source                   out_ch
);

	logic [6:0]         dev_addr_q;
	logic [7:0]         reg_ptr_q;
	logic               cfg_wr;
	logic               accept;
	isp_pkg::slot_res_t slot_res;
	isp_pkg::slot_res_t res_q;
	logic               res_valid_q;

	// Register port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_addr_q <= isp_pkg::DEV_ADDR_RST;
			reg_ptr_q  <= isp_pkg::REG_PTR_RST;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				isp_pkg::REG_DEV_ADDR: dev_addr_q <= pwdata[6:0];
				isp_pkg::REG_REG_PTR:  reg_ptr_q  <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			isp_pkg::REG_DEV_ADDR: prdata = {25'd0, dev_addr_q};
			isp_pkg::REG_REG_PTR:  prdata = {24'd0, reg_ptr_q};
			default:               prdata = '0;
		endcase
	end

	// Take a slot word whenever the output register is free or draining
	assign in_ch.ready = !res_valid_q || out_ch.ready;
	assign accept      = in_ch.valid && in_ch.ready;

	isp_seq u_seq (
		.clk              (clk),
		.arst_n           (arst_n),
		.step_en          (accept),
		.start_request    (in_ch.start_request),
		.sda_in           (in_ch.sda_in),
		.device_address   (dev_addr_q),
		.register_pointer (reg_ptr_q),
		.res              (slot_res)
	);

	// Hold the result word until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= accept || (res_valid_q && !out_ch.ready);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= slot_res;
		end
	end

	assign out_ch.valid         = res_valid_q;
	assign out_ch.scl_level     = res_q.scl_level;
	assign out_ch.sda_level     = res_q.sda_level;
	assign out_ch.sda_drive     = res_q.sda_drive;
	assign out_ch.busy_res      = res_q.busy_res;
	assign out_ch.reading_valid = res_q.reading_valid;
	assign out_ch.temperature   = res_q.temperature;
	assign out_ch.led_bar       = res_q.led_bar;
	assign out_ch.relay_on      = res_q.relay_on;

	a_idle_scl_high: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.busy_res && !out_ch.reading_valid |-> out_ch.scl_level)
		else $error("SCL low on an idle bus");

	a_stop_bus_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.reading_valid |->
		out_ch.scl_level && out_ch.sda_level && out_ch.sda_drive && !out_ch.busy_res)
		else $error("STOP slot without released bus levels");

	a_word_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> res_valid_q)
		else $error("accepted slot word missing from output register");

endmodule

>>> dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: slot-level check of the I2C sensor poll block
// Feeds bus slots (start request, sampled SDA) through the input channel in
// random bursts, drains result words under a shifting stall pattern, and
// compares every word against a cycle-free model of the bit-banged register
// read. Covers address/pointer extremes over APB and thermometer band edges.
// ----------------------------------------------------------------------------
module tb_top;
	import isp_pkg::*;

	// Length of one read transaction in slots, counted from the start request
	localparam int XFER_SLOTS   = 81;
	// Slot offsets at which the eight data bits are sampled (SCL high half)
	localparam int READ_FIRST   = 60;
	localparam int READ_LAST    = 74;
	localparam int SLOTS_PER_PHASE = 290;
	localparam int NUM_PHASES   = 5;

	typedef struct packed {
		logic start_request;
		logic sda_in;
	} bus_slot_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	isp_in_if  in_ch();
	isp_out_if out_ch();

	i2c_sensor_poll_bar_graph_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.in_ch   (in_ch),
		.out_ch  (out_ch)
	);

	// Temperatures on and around every band edge and the relay trip point
	logic [7:0] band_edges [0:17] = '{8'd0, 8'd29, 8'd30, 8'd34, 8'd35, 8'd39, 8'd40,
		8'd44, 8'd45, 8'd49, 8'd50, 8'd51, 8'd54, 8'd55, 8'd59, 8'd60, 8'd61, 8'd255};

	// Sequencer model state
	step_t      seq_step  = ST_IDLE;
	logic [3:0] bit_cnt   = 4'd0;
	logic       clk_half  = 1'b0;
	logic [7:0] shift_reg = 8'd0;
	logic [7:0] temp_reg  = 8'd0;
	logic [5:0] bar_reg   = 6'd0;
	logic       relay_reg = 1'b0;
	logic [6:0] dev_addr  = DEV_ADDR_RST;
	logic [7:0] reg_ptr   = REG_PTR_RST;

	bus_slot_t slots_to_send [$];
	slot_res_t slot_words_due [$];
	int n_queued = 0;
	int n_taken  = 0;
	int n_errors = 0;

	logic in_taken = 1'b0;
	int   gap_left = 0;
	int   burst_left = 1;
	int   stall_mode = 0;
	int   mode_left = 0;
	logic [7:0] rx_tick = 8'd0;

	// Free-running clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Thermometer code: one LED per 5-degree band starting at the low edge
	function automatic logic [5:0] led_code(input logic [7:0] t);
		int lit;
		if (t < BAR_LO || t > BAR_HI) return 6'h00;
		lit = (int'(t) - int'(BAR_LO)) / 5 + 1;
		if (lit > 6) lit = 6;
		return 6'((1 << lit) - 1);
	endfunction

	// Advance the sequencer model by one bus slot and form the result word
	function automatic slot_res_t next_bus_slot(input logic req, input logic sda);
		slot_res_t r;
		step_t s;
		logic scl, lvl, drv, done;
		s = seq_step;
		scl = 1'b1;
		lvl = 1'b1;
		drv = 1'b0;
		done = 1'b0;
		case (s)
			ST_START, ST_RESTART: begin
				drv = 1'b1;
				if (bit_cnt == COND_PH0) begin
					bit_cnt = COND_PH1;
				end else if (bit_cnt == COND_PH1) begin
					lvl = 1'b0;
					bit_cnt = COND_PH2;
				end else begin
					scl = 1'b0;
					lvl = 1'b0;
					bit_cnt = 4'd0;
					clk_half = 1'b0;
					if (s == ST_START) begin
						seq_step = ST_ADDRW;
						shift_reg = {dev_addr, 1'b0};
					end else begin
						seq_step = ST_ADDRR;
						shift_reg = {dev_addr, 1'b1};
					end
				end
			end
			ST_ADDRW, ST_REG, ST_ADDRR: begin
				drv = 1'b1;
				lvl = shift_reg[7];
				if (!clk_half) begin
					clk_half = 1'b1;
				end else begin
					scl = 1'b0;
					clk_half = 1'b0;
					shift_reg = {shift_reg[6:0], 1'b0};
					bit_cnt = bit_cnt + 4'd1;
					if (bit_cnt >= BYTE_BITS) begin
						bit_cnt = 4'd0;
						seq_step = step_t'(s + 4'd1);
					end
				end
			end
			ST_ACK1, ST_ACK2, ST_ACK3: begin
				lvl = 1'b0;
				if (!clk_half) begin
					clk_half = 1'b1;
				end else begin
					scl = 1'b0;
					drv = 1'b1;
					clk_half = 1'b0;
					bit_cnt = 4'd0;
					seq_step = step_t'(s + 4'd1);
					if (s == ST_ACK1) shift_reg = reg_ptr;
					else if (s == ST_ACK3) shift_reg = 8'd0;
				end
			end
			ST_READ: begin
				lvl = 1'b0;
				if (!clk_half) begin
					clk_half = 1'b1;
					shift_reg = {shift_reg[6:0], sda};
				end else begin
					scl = 1'b0;
					clk_half = 1'b0;
					bit_cnt = bit_cnt + 4'd1;
					if (bit_cnt >= BYTE_BITS) begin
						bit_cnt = 4'd0;
						seq_step = ST_NACK;
					end
				end
			end
			ST_NACK: begin
				drv = 1'b1;
				if (!clk_half) begin
					clk_half = 1'b1;
				end else begin
					scl = 1'b0;
					clk_half = 1'b0;
					bit_cnt = 4'd0;
					seq_step = ST_STOP;
				end
			end
			ST_STOP: begin
				drv = 1'b1;
				if (bit_cnt == COND_PH0) begin
					scl = 1'b0;
					lvl = 1'b0;
					bit_cnt = COND_PH1;
				end else if (bit_cnt == COND_PH1) begin
					lvl = 1'b0;
					bit_cnt = COND_PH2;
				end else begin
					done = 1'b1;
					temp_reg = shift_reg;
					bar_reg = led_code(shift_reg);
					relay_reg = (shift_reg == RELAY_TEMP);
					bit_cnt = 4'd0;
					clk_half = 1'b0;
					seq_step = ST_IDLE;
				end
			end
			default: begin
				// Idle, or an unused step code: a start request opens START
				seq_step = ST_IDLE;
				bit_cnt = 4'd0;
				clk_half = 1'b0;
				if (req) begin
					drv = 1'b1;
					seq_step = ST_START;
					bit_cnt = COND_PH1;
				end
			end
		endcase
		r.scl_level = scl;
		r.sda_level = lvl;
		r.sda_drive = drv;
		r.busy_res = (seq_step != ST_IDLE);
		r.reading_valid = done;
		r.temperature = temp_reg;
		r.led_bar = bar_reg;
		r.relay_on = relay_reg;
		return r;
	endfunction

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			n_errors++;
		end
	endtask

	// Check each drained result word, then predict the word for a taken slot
	always @(posedge clk) begin : scoreboard
		slot_res_t want;
		if (!arst_n) begin
			in_taken <= 1'b0;
		end else begin
			in_taken <= in_ch.valid && in_ch.ready;
			if (out_ch.valid && out_ch.ready) begin
				if (slot_words_due.size() == 0) begin
					$error("result word with nothing expected");
					n_errors++;
				end else begin
					want = slot_words_due.pop_front();
					check_field("scl_level", want.scl_level, out_ch.scl_level);
					check_field("sda_level", want.sda_level, out_ch.sda_level);
					check_field("sda_drive", want.sda_drive, out_ch.sda_drive);
					check_field("busy_res", want.busy_res, out_ch.busy_res);
					check_field("reading_valid", want.reading_valid, out_ch.reading_valid);
					check_field("temperature", want.temperature, out_ch.temperature);
					check_field("led_bar", want.led_bar, out_ch.led_bar);
					check_field("relay_on", want.relay_on, out_ch.relay_on);
				end
			end
			if (in_ch.valid && in_ch.ready) begin
				slot_words_due.push_back(next_bus_slot(in_ch.start_request, in_ch.sda_in));
				n_taken++;
			end
		end
	end

	// Slot driver: bursts of words separated by random gaps
	always @(negedge clk) begin : slot_driver
		bus_slot_t cur;
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.start_request <= 1'b0;
			in_ch.sda_in <= 1'b0;
		end else if (!in_ch.valid || in_taken) begin
			if (gap_left != 0) begin
				in_ch.valid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (slots_to_send.size() != 0) begin
				cur = slots_to_send.pop_front();
				in_ch.valid <= 1'b1;
				in_ch.start_request <= cur.start_request;
				in_ch.sda_in <= cur.sda_in;
				if (burst_left <= 1) begin
					burst_left <= ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 24);
					gap_left <= $urandom_range(0, 6);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// Result sink: switch at random among four stall patterns
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			rx_tick <= rx_tick + 8'd1;
			case (stall_mode)
				0: out_ch.ready <= 1'b1;
				1: out_ch.ready <= ($urandom_range(0, 2) != 0);
				2: out_ch.ready <= rx_tick[0];
				default: out_ch.ready <= (rx_tick[2:0] == 3'd0);
			endcase
			if (mode_left == 0) begin
				stall_mode <= $urandom_range(0, 3);
				mode_left <= $urandom_range(16, 96);
			end else begin
				mode_left <= mode_left - 1;
			end
		end
	end

	task automatic add_slot(input logic req, input logic sda);
		slots_to_send.push_back('{req, sda});
		n_queued++;
	endtask

	// Queue one full register read that returns the given byte; start
	// requests while busy are sprinkled in to show they are ignored
	task automatic add_read(input logic [7:0] t);
		add_slot(1'b1, 1'($urandom_range(0, 1)));
		for (int k = 1; k < XFER_SLOTS; k++) begin
			if (k >= READ_FIRST && k <= READ_LAST && (k % 2) == 0)
				add_slot(1'($urandom_range(0, 1)), t[7 - (k - READ_FIRST) / 2]);
			else
				add_slot(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
		end
	endtask

	task automatic wait_drained();
		while (n_taken != n_queued || slot_words_due.size() != 0) @(posedge clk);
	endtask

	task automatic apb_write(input logic [0:0] idx, input logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == REG_DEV_ADDR) dev_addr = value[6:0];
		else reg_ptr = value[7:0];
	endtask

	// Stimulus: directed opening, then phases of reads under new settings
	initial begin
		int n_reads;
		n_reads = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Idle slots with both SDA levels, then a relay reading and a
		// read that starts on the slot right after STOP
		add_slot(1'b0, 1'b0);
		add_slot(1'b0, 1'b1);
		add_read(RELAY_TEMP);
		add_read(8'd255);

		for (int p = 0; p < NUM_PHASES; p++) begin
			if (p != 0) begin
				// Hold until the pipe and the bus sequence are both idle
				wait_drained();
				while (seq_step != ST_IDLE) begin
					add_slot(1'b0, 1'($urandom_range(0, 1)));
					wait_drained();
				end
				repeat (4) @(posedge clk);
				case (p)
					1: begin
						apb_write(REG_DEV_ADDR, 32'd127);
						apb_write(REG_REG_PTR, 32'd255);
					end
					2: begin
						apb_write(REG_DEV_ADDR, 32'd0);
						apb_write(REG_REG_PTR, 32'd0);
					end
					default: begin
						apb_write(REG_DEV_ADDR, $urandom_range(0, 127));
						apb_write(REG_REG_PTR, $urandom_range(0, 255));
					end
				endcase
			end
			while (n_queued < (p + 1) * SLOTS_PER_PHASE) begin
				repeat ($urandom_range(0, 6)) add_slot(1'b0, 1'($urandom_range(0, 1)));
				if (n_reads % 5 == 4)
					add_read(8'($urandom_range(0, 255)));
				else
					add_read(band_edges[n_reads % 18]);
				n_reads++;
			end
		end

		wait_drained();
		repeat (5) @(posedge clk);
		if (n_errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#3000000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
